// File: hw/rtl/triangle_barycentric_coords_core_macros.svh
// Assertion macros for the barycentric coordinate core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_CORE_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbc implication check failed");

// Implication after a fixed number of cycles
`define TBC_ASSERT_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("tbc latency check failed");

`endif

// File: hw/rtl/tbc_pkg.sv
// Shared widths, latencies and types of the barycentric coordinate core.
// No dependencies.
package tbc_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 24;
  localparam int DIF_W      = COORD_BITS + 1;
  localparam int PRD_W      = 2 * DIF_W;
  localparam int CRS_W      = PRD_W + 1;
  localparam int MAG_W      = CRS_W;
  localparam int Q_BITS     = OUT_BITS - 1;
  localparam int INT_BITS   = Q_BITS - FRAC_BITS;
  localparam int FRONT_LAT  = 4;
  localparam int DIV_LAT    = Q_BITS + 2;
  localparam int CORE_LAT   = FRONT_LAT + DIV_LAT;

  localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic degen;
  } tbc_ctl_t;
endpackage

// File: hw/rtl/triangle_barycentric_coords_core.sv
// Barycentric coordinates of a point in a 2D triangle, signed Q7.16 out.
// Takes one query per clock with no stall: busy is always low. Each result
// appears on the out_ ports one cycle wide, marked by out_valid; the receiver
// must take it then. The pipeline is made of four front stages (differences,
// 17x17 products, cross products, magnitudes) and a 25-stage restoring divider
// per weight: one load stage, 23 stages of one quotient bit each, and one round
// and saturate stage.
// Zero area gives out_degenerate high and zero weights.
// Depends on tbc_pkg, tbc_front, tbc_div and the assertion macro header.
`include "triangle_barycentric_coords_core_macros.svh"

module triangle_barycentric_coords_core import tbc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_c_x,
  input  logic signed [COORD_BITS-1:0] in_c_y,
  output logic                         out_valid,
  output logic signed [OUT_BITS-1:0]   out_coord_u,
  output logic signed [OUT_BITS-1:0]   out_coord_v,
  output logic signed [OUT_BITS-1:0]   out_coord_w,
  output logic                         out_degenerate
);

  logic [MAG_W-1:0]    mag_u, mag_v, mag_w, den;
  logic                neg_u, neg_v, neg_w;
  tbc_ctl_t            ctl_f, ctl_u, ctl_v, ctl_w;
  logic [OUT_BITS-1:0] cu, cv, cw;

  // fully pipelined, never holds off a transfer
  assign busy = 1'b0;

  tbc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .px     (in_point_x),
    .py     (in_point_y),
    .ax     (in_a_x),
    .ay     (in_a_y),
    .bx     (in_b_x),
    .by     (in_b_y),
    .cx     (in_c_x),
    .cy     (in_c_y),
    .mag_u  (mag_u),
    .mag_v  (mag_v),
    .mag_w  (mag_w),
    .neg_u  (neg_u),
    .neg_v  (neg_v),
    .neg_w  (neg_w),
    .den    (den),
    .ctl    (ctl_f)
  );

  tbc_div u_div_u (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl_f), .num(mag_u), .neg_in(neg_u),
    .den(den), .ctl_out(ctl_u), .coord(cu)
  );

  tbc_div u_div_v (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl_f), .num(mag_v), .neg_in(neg_v),
    .den(den), .ctl_out(ctl_v), .coord(cv)
  );

  tbc_div u_div_w (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl_f), .num(mag_w), .neg_in(neg_w),
    .den(den), .ctl_out(ctl_w), .coord(cw)
  );

  assign out_valid      = ctl_u.valid;
  assign out_degenerate = ctl_u.degen;
  assign out_coord_u    = $signed(cu);
  assign out_coord_v    = $signed(cv);
  assign out_coord_w    = $signed(cw);

  // lanes stay in lockstep, latency is fixed, degenerate zeroes the weights
  `TBC_ASSERT_IMP(a_lanes_agree, 1'b1, (ctl_u == ctl_v) && (ctl_u == ctl_w))
  `TBC_ASSERT_DLY(a_fixed_latency, start && !busy, 29, out_valid)
  `TBC_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate,
                  (cu == '0) && (cv == '0) && (cw == '0))

endmodule

// File: hw/rtl/tbc_front.sv
// Front pipeline: edge differences, products, cross products, magnitudes.
// Depends on tbc_pkg.
module tbc_front import tbc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [COORD_BITS-1:0]   px,
  input  logic [COORD_BITS-1:0]   py,
  input  logic [COORD_BITS-1:0]   ax,
  input  logic [COORD_BITS-1:0]   ay,
  input  logic [COORD_BITS-1:0]   bx,
  input  logic [COORD_BITS-1:0]   by,
  input  logic [COORD_BITS-1:0]   cx,
  input  logic [COORD_BITS-1:0]   cy,
  output logic [MAG_W-1:0]        mag_u,
  output logic [MAG_W-1:0]        mag_v,
  output logic [MAG_W-1:0]        mag_w,
  output logic                    neg_u,
  output logic                    neg_v,
  output logic                    neg_w,
  output logic [MAG_W-1:0]        den,
  output tbc_ctl_t                ctl
);

  function automatic logic signed [DIF_W-1:0] sub_d(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    sub_d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  function automatic logic signed [CRS_W-1:0] sub_p(input logic signed [PRD_W-1:0] a,
                                                    input logic signed [PRD_W-1:0] b);
    sub_p = $signed({a[PRD_W-1], a}) - $signed({b[PRD_W-1], b});
  endfunction

  function automatic logic [MAG_W-1:0] abs_c(input logic signed [CRS_W-1:0] a);
    abs_c = a[CRS_W-1] ? MAG_W'(-a) : MAG_W'(a);
  endfunction

  logic                    v1_r, v2_r, v3_r;
  logic signed [DIF_W-1:0] ba_x_r, ba_y_r, ca_x_r, ca_y_r;
  logic signed [DIF_W-1:0] ap_x_r, ap_y_r, bp_x_r, bp_y_r, cp_x_r, cp_y_r;
  logic signed [PRD_W-1:0] pa0_r, pa1_r, pu0_r, pu1_r, pv0_r, pv1_r, pw0_r, pw1_r;
  logic signed [CRS_W-1:0] cr_a_r, cr_u_r, cr_v_r, cr_w_r;
  logic [MAG_W-1:0]        mag_u_r, mag_v_r, mag_w_r, den_r;
  logic                    neg_u_r, neg_v_r, neg_w_r;
  tbc_ctl_t                ctl_r;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      v1_r        <= in_vld;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      ctl_r.valid <= v3_r;
      ctl_r.degen <= (cr_a_r == '0);
    end
  end

  // edge differences, products, cross products, magnitudes
  always_ff @(posedge clk) begin
    ba_x_r <= sub_d(bx, ax);
    ba_y_r <= sub_d(by, ay);
    ca_x_r <= sub_d(cx, ax);
    ca_y_r <= sub_d(cy, ay);
    ap_x_r <= sub_d(ax, px);
    ap_y_r <= sub_d(ay, py);
    bp_x_r <= sub_d(bx, px);
    bp_y_r <= sub_d(by, py);
    cp_x_r <= sub_d(cx, px);
    cp_y_r <= sub_d(cy, py);

    pa0_r <= ca_x_r * ba_y_r;
    pa1_r <= ba_x_r * ca_y_r;
    pu0_r <= cp_x_r * bp_y_r;
    pu1_r <= bp_x_r * cp_y_r;
    pv0_r <= ap_x_r * cp_y_r;
    pv1_r <= cp_x_r * ap_y_r;
    pw0_r <= bp_x_r * ap_y_r;
    pw1_r <= ap_x_r * bp_y_r;

    cr_a_r <= sub_p(pa0_r, pa1_r);
    cr_u_r <= sub_p(pu0_r, pu1_r);
    cr_v_r <= sub_p(pv0_r, pv1_r);
    cr_w_r <= sub_p(pw0_r, pw1_r);

    den_r   <= abs_c(cr_a_r);
    mag_u_r <= abs_c(cr_u_r);
    mag_v_r <= abs_c(cr_v_r);
    mag_w_r <= abs_c(cr_w_r);
    neg_u_r <= cr_u_r[CRS_W-1];
    neg_v_r <= cr_v_r[CRS_W-1];
    neg_w_r <= cr_w_r[CRS_W-1];
  end

  assign mag_u = mag_u_r;
  assign mag_v = mag_v_r;
  assign mag_w = mag_w_r;
  assign neg_u = neg_u_r;
  assign neg_v = neg_v_r;
  assign neg_w = neg_w_r;
  assign den   = den_r;
  assign ctl   = ctl_r;

endmodule

// File: hw/rtl/tbc_div.sv
// Pipelined restoring divider: one quotient bit per stage, round and saturate.
// Depends on tbc_pkg.
module tbc_div import tbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbc_ctl_t              ctl_in,
  input  logic [MAG_W-1:0]      num,
  input  logic                  neg_in,
  input  logic [MAG_W-1:0]      den,
  output tbc_ctl_t              ctl_out,
  output logic [OUT_BITS-1:0]   coord
);

  logic [MAG_W-1:0]    rem_r  [0:Q_BITS];
  logic [MAG_W-1:0]    den_r  [0:Q_BITS];
  logic [Q_BITS-1:0]   bits_r [0:Q_BITS];
  logic [Q_BITS-1:0]   quo_r  [0:Q_BITS];
  logic                neg_r  [0:Q_BITS];
  logic                ovf_r  [0:Q_BITS];
  tbc_ctl_t            ctl_r  [0:Q_BITS];

  logic                ovf_nxt;
  logic [MAG_W:0]      rnd_cmp;
  logic                rnd;
  logic [Q_BITS:0]     mag;
  logic                sat;
  logic [OUT_BITS-1:0] coord_nxt;
  logic [OUT_BITS-1:0] coord_r;
  tbc_ctl_t            cout_r;

  // overflow when the integer part of the quotient does not fit in INT_BITS bits
  assign ovf_nxt = {{INT_BITS{1'b0}}, num} >= {den, {INT_BITS{1'b0}}};

  // load first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= MAG_W'(num[MAG_W-1:INT_BITS]);
    bits_r[0] <= {num[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
    quo_r[0]  <= '0;
    den_r[0]  <= den;
    neg_r[0]  <= neg_in;
    ovf_r[0]  <= ovf_nxt;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= Q_BITS; k++) begin : g_stage
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             ge;
    logic [MAG_W-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], bits_r[k-1][Q_BITS-1]};
    assign ge      = trial >= {1'b0, den_r[k-1]};
    assign diff    = trial - {1'b0, den_r[k-1]};
    assign rem_nxt = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      bits_r[k] <= {bits_r[k-1][Q_BITS-2:0], 1'b0};
      quo_r[k]  <= {quo_r[k-1][Q_BITS-2:0], ge};
      den_r[k]  <= den_r[k-1];
      neg_r[k]  <= neg_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
    end
  end

  // round half away from zero, saturate, apply sign
  assign rnd_cmp = {rem_r[Q_BITS], 1'b0};
  assign rnd     = rnd_cmp >= {1'b0, den_r[Q_BITS]};
  assign mag     = {1'b0, quo_r[Q_BITS]} + (Q_BITS+1)'(rnd);
  assign sat     = ovf_r[Q_BITS] | mag[Q_BITS];

  always_comb begin
    if (ctl_r[Q_BITS].degen) begin
      coord_nxt = '0;
    end else if (neg_r[Q_BITS]) begin
      coord_nxt = sat ? OUT_MIN : OUT_BITS'(-mag);
    end else begin
      coord_nxt = sat ? OUT_MAX : OUT_BITS'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r <= '0;
    end else begin
      cout_r <= ctl_r[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    coord_r <= coord_nxt;
  end

  assign ctl_out = cout_r;
  assign coord   = coord_r;

endmodule
